FILE: src/g16fpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g16fpe_pkg: shared constants for the 16-level plane encoder
// Holds the dither page table and the page saturation helper.
// ----------------------------------------------------------------------------
package g16fpe_pkg;

	localparam int PAGES      = 5;
	localparam int LEVELS     = 16;
	localparam int ROW_PIXELS = 8;
	localparam int PAGE_W     = 3;
	localparam int PAGE_IDX_W = $clog2(PAGES);

	typedef logic [PAGE_IDX_W-1:0] page_idx_t;

	// Plane pair per level: bit 0 is plane 0, bit 1 is plane 1.
	localparam logic [1:0] FRC_TABLE [PAGES][LEVELS] = '{
		'{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2,
		  2'd1, 2'd1, 2'd1, 2'd3, 2'd1, 2'd3, 2'd3, 2'd3},
		'{2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd1,
		  2'd2, 2'd1, 2'd1, 2'd1, 2'd3, 2'd1, 2'd3, 2'd3},
		'{2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		  2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3},
		'{2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd1,
		  2'd2, 2'd1, 2'd1, 2'd1, 2'd3, 2'd1, 2'd3, 2'd3},
		'{2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2,
		  2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd3, 2'd1, 2'd3}
	};

	// Pages beyond the table use the last page.
	function automatic page_idx_t page_sat(input logic [PAGE_W-1:0] pg);
		if (pg >= PAGE_W'(PAGES - 1)) begin
			page_sat = PAGE_IDX_W'(PAGES - 1);
		end else begin
			page_sat = PAGE_IDX_W'(pg);
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/g16fpe_row_enc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g16fpe_row_enc: one-row plane encoder
// Applies the overlay to eight pixels and looks each level up in the page table.
// ----------------------------------------------------------------------------
module g16fpe_row_enc
	import g16fpe_pkg::*;
(
	input  wire logic [4*ROW_PIXELS-1:0] pixels,
	input  wire logic [3*ROW_PIXELS-1:0] overlay,
	input  wire page_idx_t               page_idx,
	input  wire logic                    overlay_en,
	output logic [2*ROW_PIXELS-1:0]      planes
);

	always_comb begin
		logic [3:0] lvl;
		logic [2:0] code;
		logic [1:0] pair;
		planes = '0;
		for (int k = 0; k < ROW_PIXELS; k++) begin
			lvl  = pixels[4*k +: 4];
			code = overlay[3*k +: 3];
			// Color times five is the two color bits repeated.
			if (overlay_en && !code[2]) begin
				lvl = {code[1:0], code[1:0]};
			end
			pair = FRC_TABLE[page_idx][lvl];
			planes[k]              = pair[0];
			planes[ROW_PIXELS + k] = pair[1];
		end
	end

endmodule
`default_nettype wire

FILE: src/gray16_frc_plane_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gray16_frc_plane_encoder: 16-level grayscale to LCD bit-plane word encoder
// Packs two rows of eight pixels into one dithered two-plane 32-bit word.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------
//  input     in_valid / in_ready   upper/lower_row_pixels, _overlay, page
//  output    out_valid / out_ready plane_word
//  config    cfg_wr_en             cfg_wr_data (overlay_enable)
//
// Each transfer on the input yields exactly one output transfer. An item
// passes through the input register and then the result register, with
// the table lookup between them; one item per cycle is sustained while
// the output is not stalled. A stall on the output holds the result
// register and, if the input register is also full, deasserts in_ready in
// the same cycle. Reset clears both valid flags and overlay_enable.
//
module gray16_frc_plane_encoder
	import g16fpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] upper_row_pixels,
	input  wire logic [31:0] lower_row_pixels,
	input  wire logic [23:0] upper_row_overlay,
	input  wire logic [23:0] lower_row_overlay,
	input  wire logic [2:0]  page,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      plane_word
);

	logic        overlay_enable_q;
	logic        valid_s1;
	logic        valid_s2;
	logic [31:0] upper_pix_s1;
	logic [31:0] lower_pix_s1;
	logic [23:0] upper_ovl_s1;
	logic [23:0] lower_ovl_s1;
	page_idx_t   page_s1;
	logic [31:0] plane_word_s2;
	logic [15:0] upper_planes;
	logic [15:0] lower_planes;
	logic        adv_s1;

	// The configuration register; the user must write it only while the block is idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			overlay_enable_q <= cfg_wr_data;
		end
	end

	// Stage 1 moves on whenever the result register is empty or being taken.
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The page is saturated on the way in so the table index stays in range.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			upper_pix_s1 <= upper_row_pixels;
			lower_pix_s1 <= lower_row_pixels;
			upper_ovl_s1 <= upper_row_overlay;
			lower_ovl_s1 <= lower_row_overlay;
			page_s1      <= page_sat(page);
		end
	end

	g16fpe_row_enc u_upper_enc (
		.pixels     (upper_pix_s1),
		.overlay    (upper_ovl_s1),
		.page_idx   (page_s1),
		.overlay_en (overlay_enable_q),
		.planes     (upper_planes)
	);

	g16fpe_row_enc u_lower_enc (
		.pixels     (lower_pix_s1),
		.overlay    (lower_ovl_s1),
		.page_idx   (page_s1),
		.overlay_en (overlay_enable_q),
		.planes     (lower_planes)
	);

	// Result register: upper row in the low half, lower row in the high half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			plane_word_s2 <= {lower_planes, upper_planes};
		end
	end

	assign out_valid  = valid_s2;
	assign plane_word = plane_word_s2;

	// An accepted input always lands in stage 1.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted input did not reach stage 1");

	// A held stage 1 keeps its item while the result register is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(page_s1) &&
			$stable(upper_pix_s1) && $stable(lower_pix_s1)))
		else $error("stage 1 item lost during a stall");

	// A stage 1 item that advances shows up as a result.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> out_valid)
		else $error("stage 1 item did not reach the output");

	// Input is refused only when both stages are full and the output stalls.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low without a full stalled pipeline");

endmodule
`default_nettype wire
